// ===== hw/rtl/des_block_encrypt_defines.svh =====
// assertion macros for the des block encrypt checker
`ifndef DES_BLOCK_ENCRYPT_DEFINES_SVH
`define DES_BLOCK_ENCRYPT_DEFINES_SVH

// implication checked outside reset
`define DBE_ASSERT_IMP(name, clk_i, rstn_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define DBE_ASSERT_NXT(name, clk_i, rstn_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication checked at every edge, reset included
`define DBE_ASSERT_ALWAYS(name, clk_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dbe_pkg.sv =====
// des tables, permutation functions and round function
package dbe_pkg;

  localparam int Rounds = 16;

  localparam logic KEY_IDX = 1'b0;

  localparam logic [1:0] ROT_TAB [0:15] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [6:0] PC1_TAB [0:55] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [0:47] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [6:0] IP_TAB [0:63] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [5:0] EXP_TAB [0:47] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [3:0] SBOX_TAB [0:7][0:63] = '{
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
      4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
      4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
      4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
      4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
      4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
      4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
      4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
      4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
      4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
      4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
      4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
      4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
      4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
      4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
      4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
      4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
      4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
      4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
      4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
      4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
      4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
      4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
      4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
      4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
      4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
      4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
      4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
      4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
      4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
      4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
      4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
      4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
      4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
      4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
      4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
      4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
      4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
  };

  localparam logic [5:0] PBOX_TAB [0:31] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] FP_TAB [0:63] = '{
    7'd40, 7'd8,  7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7,  7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6,  7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5,  7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4,  7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3,  7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2,  7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1,  7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  typedef logic [Rounds-1:0][47:0] subkey_set_t;

  // table entries count bits from the msb, starting at one
  function automatic logic [55:0] pc1_perm(input logic [63:0] src);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) begin
      r[55-i] = src[6'(7'd64 - PC1_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] src);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) begin
      r[47-i] = src[6'(7'd56 - {1'b0, PC2_TAB[i]})];
    end
    return r;
  endfunction

  function automatic logic [63:0] ip_perm(input logic [63:0] src);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = src[6'(7'd64 - IP_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] src);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[63-i] = src[6'(7'd64 - FP_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [47:0] exp_perm(input logic [31:0] src);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) begin
      r[47-i] = src[5'(6'd32 - EXP_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] src);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[31-i] = src[5'(6'd32 - PBOX_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [31:0] sbox_sub(input logic [47:0] e);
    logic [31:0] r;
    logic [5:0]  six;
    for (int j = 0; j < 8; j++) begin
      six = e[47-6*j -: 6];
      r[31-4*j -: 4] = SBOX_TAB[j][{six[5], six[0], six[4:1]}];
    end
    return r;
  endfunction

  function automatic subkey_set_t key_sched(input logic [63:0] key);
    subkey_set_t ks;
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    cd = pc1_perm(key);
    c  = cd[55:28];
    d  = cd[27:0];
    for (int i = 0; i < Rounds; i++) begin
      if (ROT_TAB[i] == 2'd1) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end else begin
        c = {c[25:0], c[27:26]};
        d = {d[25:0], d[27:26]};
      end
      ks[i] = pc2_perm({c, d});
    end
    return ks;
  endfunction

  // {l, r} in, {r, l ^ f(r, k)} out
  function automatic logic [63:0] des_round(input logic [63:0] lr, input logic [47:0] k);
    logic [31:0] f;
    f = p_perm(sbox_sub(exp_perm(lr[31:0]) ^ k));
    return {lr[31:0], lr[63:32] ^ f};
  endfunction

endpackage

// ===== hw/rtl/des_block_encrypt.sv =====
// des block encrypt top level: key register and sixteen-round pipeline
//
// usage
//   input channel: in_valid/in_ready carry one 64-bit plaintext word
//   (in_plain_block); output channel: out_valid/out_ready carry one 64-bit
//   ciphertext word (out_cipher_block). words leave in the order they enter.
//   the key is written through the apb port at addresses 0 to 7 (64-bit data)
//   and must only change while no word is in flight. reads there return the key.
//   pipeline: an accepted word passes one input register with the initial
//   permutation, then one register per des round, before out_valid rises.
//   throughput: one word per cycle while not stalled; each round stage holds one round.
//   reset: all stage valid bits clear, the key resets to zero.
//   stall: a stage only holds while its successor is full and held, so
//   bubbles squeeze out and in_ready stays high while any stage is empty.
//   with the pipeline full and out_ready low, in_ready drops.
module des_block_encrypt
  import dbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_block,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_r;
  logic        key_wr;
  subkey_set_t subkey;

  logic [63:0] data_r   [0:Rounds];
  logic [63:0] data_nxt [0:Rounds];
  logic        vld_r    [0:Rounds];
  logic        vld_nxt  [0:Rounds];
  logic        adv      [0:Rounds];

  assign pready = 1'b1;
  assign key_wr = psel && penable && pwrite && (paddr[3] == KEY_IDX);
  assign prdata = (paddr[3] == KEY_IDX) ? key_r : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= 64'd0;
    end else if (key_wr) begin
      key_r <= pwdata;
    end
  end

  assign subkey = key_sched(key_r);

  assign adv[Rounds] = !vld_r[Rounds] || out_ready;
  assign in_ready    = adv[0];

  assign data_nxt[0] = ip_perm(in_plain_block);
  assign vld_nxt[0]  = in_valid;

  for (genvar i = 0; i < Rounds; i++) begin : g_round
    assign adv[i]        = !vld_r[i] || adv[i+1];
    assign data_nxt[i+1] = des_round(data_r[i], subkey[i]);
    assign vld_nxt[i+1]  = vld_r[i];
  end

  for (genvar i = 0; i <= Rounds; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_r[i] <= vld_nxt[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        data_r[i] <= data_nxt[i];
      end
    end
  end

  // halves swap before the final permutation
  assign out_valid        = vld_r[Rounds];
  assign out_cipher_block = fp_perm({data_r[Rounds][31:0], data_r[Rounds][63:32]});

endmodule

// ===== hw/rtl/dbe_checker.sv =====
// port-level assertion checker for des block encrypt, with its bind
`include "des_block_encrypt_defines.svh"

module dbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_cipher_block
);

  `DBE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "output word after reset")

  `DBE_ASSERT_IMP(a_ready_flow, clk, rst_n, out_ready, in_ready, "input blocked while output drains")

  `DBE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output word dropped")

  `DBE_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_cipher_block), "stalled output word changed")

endmodule

bind des_block_encrypt dbe_checker u_dbe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_cipher_block (out_cipher_block)
);
